// ===== rtl/kms_pkg.sv =====
// Shared types and constants for the key matrix scanner with debounce.
package kms_pkg;

    localparam int SCAN_ROWS_DEF     = 4;
    localparam int SENSE_COLUMNS_DEF = 3;

    localparam int CNT_W    = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [CNT_W-1:0] BOUNCE_RESET = 16'd50;
    localparam logic [CNT_W-1:0] HOLD_RESET   = 16'd300;

    // Register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_BOUNCE = 1'b0,
        REG_HOLD   = 1'b1
    } kms_reg_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_BOUNCE = 3'b010,
        MODE_HOLD   = 3'b100
    } kms_mode_t;

    typedef struct packed {
        logic [CNT_W-1:0] bounce_ticks;
        logic [CNT_W-1:0] hold_ticks;
    } kms_cfg_t;

endpackage

// ===== rtl/key_matrix_scanner_debounce_core.sv =====
// Top level: key matrix scan sequencer, press debounce and hold timing.
//
// One input item is one scan tick carrying the active-low column sense lines
// (column_lines) sampled while the current row is driven low. Each item gives
// exactly one result item: the active-low row drive for the next scan phase,
// and a press report (press_valid, press_row, press_column) when a new key
// press is seen in idle. A press starts a bounce wait of bounce_ticks, then
// hold waits of hold_ticks; the block returns to idle only when a hold wait
// ends with all columns released.
// The result is loaded into the output register when the item is accepted.
// Throughput: one item per cycle while results are taken; the mode, counter
// and phase update is a short compare/decrement path between the accepted
// item and the state registers.
// Reset (rst_n low, asynchronous) clears the mode to idle, the counter and
// scan phase to zero, empties the output register, and restores the tick
// counts to 50 and 300. When the receiver stalls, the result holds in the
// output register and in_ready drops until it is taken; a new item is taken
// in the same cycle the held result leaves. Write the registers over APB
// (bounce_ticks at 0x0, hold_ticks at 0x4) only while the block is idle.
module key_matrix_scanner_debounce_core
    import kms_pkg::*;
#(
    parameter int SCAN_ROWS     = SCAN_ROWS_DEF,
    parameter int SENSE_COLUMNS = SENSE_COLUMNS_DEF,
    localparam int ROW_W = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1,
    localparam int COL_W = (SENSE_COLUMNS > 1) ? $clog2(SENSE_COLUMNS) : 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SENSE_COLUMNS-1:0] column_lines,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [SCAN_ROWS-1:0]     row_drive,
    output logic                     press_valid,
    output logic [ROW_W-1:0]         press_row,
    output logic [COL_W-1:0]         press_column,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    kms_cfg_t          cfg;

    kms_mode_t         mode_reg;
    kms_mode_t         mode_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [ROW_W-1:0]  phase_reg;
    logic [ROW_W-1:0]  phase_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SCAN_ROWS-1:0] row_drive_reg;
    logic              press_valid_reg;
    logic [ROW_W-1:0]  press_row_reg;
    logic [COL_W-1:0]  press_column_reg;

    logic              accept;
    logic              press;
    logic              released;
    logic [COL_W-1:0]  pcol;

    kms_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_ready = ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;
    assign released = &column_lines;

    // Lowest low column wins
    always_comb
    begin
        pcol = '0;
        for (int c = SENSE_COLUMNS - 1; c >= 0; c--)
        begin
            if (!column_lines[c])
                pcol = COL_W'(c);
        end
    end

    // One tick can pass through idle, bounce wait and hold wait in order
    always_comb
    begin
        press    = 1'b0;
        cnt_next = cnt_reg;
        case (mode_reg)
            MODE_BOUNCE: mode_next = MODE_BOUNCE;
            MODE_HOLD:   mode_next = MODE_HOLD;
            default:     mode_next = MODE_IDLE;
        endcase

        if (mode_next == MODE_IDLE && !released)
        begin
            press     = 1'b1;
            mode_next = MODE_BOUNCE;
            cnt_next  = cfg.bounce_ticks;
        end

        if (mode_next == MODE_BOUNCE)
        begin
            if (cnt_next != '0)
                cnt_next = cnt_next - 1'b1;
            else
            begin
                mode_next = MODE_HOLD;
                cnt_next  = cfg.hold_ticks;
            end
        end

        if (mode_next == MODE_HOLD)
        begin
            if (cnt_next != '0)
                cnt_next = cnt_next - 1'b1;
            else if (released)
                mode_next = MODE_IDLE;
            else
                cnt_next = cfg.hold_ticks;
        end

        if (phase_reg == ROW_W'(SCAN_ROWS - 1))
            phase_next = '0;
        else
            phase_next = phase_reg + 1'b1;
    end

    assign out_valid_next = accept | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                mode_reg  <= mode_next;
                cnt_reg   <= cnt_next;
                phase_reg <= phase_next;
            end
        end
    end

    // Result payload loads only with an accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_drive_reg    <= ~(SCAN_ROWS'(1) << phase_next);
            press_valid_reg  <= press;
            press_row_reg    <= press ? phase_reg : '0;
            press_column_reg <= press ? pcol : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_drive    = row_drive_reg;
    assign press_valid  = press_valid_reg;
    assign press_row    = press_row_reg;
    assign press_column = press_column_reg;

`ifndef NO_ASSERTIONS
    a_one_row_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones(~row_drive) == 1)
        else $error("row drive does not have exactly one low bit");

    a_press_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && press_valid |-> press_column < COL_W'(SENSE_COLUMNS))
        else $error("press column out of range");

    a_press_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && press |=> mode_reg != MODE_IDLE)
        else $error("press accepted but mode stayed idle");

    a_hold_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode_reg == MODE_HOLD && cnt_reg != '0
        |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("hold counter did not decrement");

    a_press_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode_reg == MODE_BOUNCE || mode_reg == MODE_HOLD) |-> !press)
        else $error("press reported outside idle");
`endif

endmodule

// ===== rtl/kms_apb_regs.sv =====
// APB register bank holding the bounce and hold tick counts.
module kms_apb_regs
    import kms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output kms_cfg_t          cfg
);

    logic [CNT_W-1:0] bounce_reg;
    logic [CNT_W-1:0] hold_reg;
    logic             wr_en;
    kms_reg_t         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = kms_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounce_reg <= BOUNCE_RESET;
            hold_reg   <= HOLD_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_BOUNCE: bounce_reg <= pwdata[CNT_W-1:0];
                REG_HOLD:   hold_reg   <= pwdata[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_BOUNCE: prdata = {{(APB_DW-CNT_W){1'b0}}, bounce_reg};
            REG_HOLD:   prdata = {{(APB_DW-CNT_W){1'b0}}, hold_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.bounce_ticks = bounce_reg;
    assign cfg.hold_ticks   = hold_reg;

endmodule

// ===== verif/key_matrix_scanner_debounce_core_tb.sv =====
// Self-checking testbench for the key matrix scanner with press debounce and hold timing.
`timescale 1ns / 100ps

module key_matrix_scanner_debounce_core_tb;
    import kms_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD_OFF  = 80;
    localparam int NUM_PHASES     = 9;
    localparam int QUIET_PHASE    = 6;

    typedef struct packed {
        logic [3:0] row_drive;
        logic       press_valid;
        logic [1:0] press_row;
        logic [1:0] press_column;
    } scan_result_t;

    // Tracks debounce state and holds the expected scan results in order
    class press_scoreboard;
        logic [CNT_W-1:0] bounce_ticks;
        logic [CNT_W-1:0] hold_ticks;
        kms_mode_t        key_mode;
        logic [CNT_W-1:0] wait_count;
        logic [1:0]       scan_phase;
        scan_result_t     expected_q[$];
        int               errors;

        function new();
            bounce_ticks = BOUNCE_RESET;
            hold_ticks   = HOLD_RESET;
            key_mode     = MODE_IDLE;
            wait_count   = '0;
            scan_phase   = '0;
            errors       = 0;
        endfunction

        function void set_reg(kms_reg_t r, logic [CNT_W-1:0] v);
            if (r == REG_BOUNCE)
                bounce_ticks = v;
            else
                hold_ticks = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
        endfunction

        // One scan tick: the mode steps run in order, so one tick may pass several
        function void note_tick(logic [2:0] cols);
            scan_result_t res;
            res = '0;
            if (key_mode == MODE_IDLE && cols != 3'b111)
            begin
                res.press_valid = 1'b1;
                res.press_row   = scan_phase;
                for (int c = SENSE_COLUMNS_DEF - 1; c >= 0; c--)
                begin
                    if (!cols[c])
                        res.press_column = 2'(c);
                end
                key_mode   = MODE_BOUNCE;
                wait_count = bounce_ticks;
            end
            if (key_mode == MODE_BOUNCE)
            begin
                if (wait_count != 0)
                    wait_count = wait_count - 1'b1;
                else
                begin
                    key_mode   = MODE_HOLD;
                    wait_count = hold_ticks;
                end
            end
            if (key_mode == MODE_HOLD)
            begin
                if (wait_count != 0)
                    wait_count = wait_count - 1'b1;
                else if (cols == 3'b111)
                    key_mode = MODE_IDLE;
                else
                    wait_count = hold_ticks;
            end
            scan_phase    = scan_phase + 1'b1;
            res.row_drive = ~(4'b0001 << scan_phase);
            expected_q.push_back(res);
        endfunction

        function void check_result(scan_result_t got);
            scan_result_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected result", '0, 32'(got));
                return;
            end
            want = expected_q.pop_front();
            if (got.row_drive !== want.row_drive)
                report("row_drive", 32'(want.row_drive), 32'(got.row_drive));
            if (got.press_valid !== want.press_valid)
                report("press_valid", 32'(want.press_valid), 32'(got.press_valid));
            if (got.press_row !== want.press_row)
                report("press_row", 32'(want.press_row), 32'(got.press_row));
            if (got.press_column !== want.press_column)
                report("press_column", 32'(want.press_column), 32'(got.press_column));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        column_lines;
    logic              out_valid;
    logic              out_ready;
    logic [3:0]        row_drive;
    logic              press_valid;
    logic [1:0]        press_row;
    logic [1:0]        press_column;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    press_scoreboard sb = new();
    bit              quiet = 1'b0;
    bit              long_hold = 1'b0;
    int              idle_cycles = 0;

    key_matrix_scanner_debounce_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .column_lines (column_lines),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .row_drive    (row_drive),
        .press_valid  (press_valid),
        .press_row    (press_row),
        .press_column (press_column),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function int pick_gap();
        if (!quiet && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 6);
        return 0;
    endfunction

    // Offer one scan tick and hold it until taken
    task automatic send_tick(logic [2:0] cols);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        column_lines <= cols;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_tick(cols);
    endtask

    // Drop valid and let every outstanding result drain
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic reg_check(kms_reg_t r, logic [CNT_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== APB_DW'(want))
            sb.report(r == REG_BOUNCE ? "bounce_ticks readback" : "hold_ticks readback",
                      APB_DW'(want), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_write(kms_reg_t r, logic [CNT_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= APB_DW'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        reg_check(r, v);
    endtask

    // Mostly press/release sequences with contact bounce, some line noise
    task automatic run_keys(int count, int span);
        int          sent;
        int          plen;
        int          rlen;
        logic [2:0]  pat;
        logic [2:0]  v;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 3) != 0)
                    pat = ~(3'b001 << $urandom_range(0, 2));
                else
                    pat = 3'($urandom_range(0, 6));
                plen = $urandom_range(1, span);
                rlen = $urandom_range(1, span);
                for (int k = 0; k < plen; k++)
                begin
                    v = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : pat;
                    send_tick(v);
                    sent++;
                end
                for (int k = 0; k < rlen; k++)
                begin
                    send_tick(3'b111);
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_tick(3'($urandom_range(0, 7)));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        logic [2:0]  directed_cols[16];
        int          bounce_tab[NUM_PHASES];
        int          hold_tab[NUM_PHASES];
        int          count_tab[NUM_PHASES];
        int          span;

        directed_cols = '{3'b111, 3'b110, 3'b110, 3'b111, 3'b101, 3'b111, 3'b011, 3'b111,
                          3'b000, 3'b111, 3'b001, 3'b111, 3'b100, 3'b111, 3'b010, 3'b111};
        bounce_tab = '{0, 1, 0, 3, 7, 2, 50, 4, 65535};
        hold_tab   = '{0, 0, 1, 5, 2, 9, 300, 4, 65535};
        count_tab  = '{180, 180, 180, 190, 190, 190, 120, 150, 60};

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        column_lines = 3'b111;
        out_ready    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_check(REG_BOUNCE, BOUNCE_RESET);
        reg_check(REG_HOLD, HOLD_RESET);
        repeat (3) send_tick(3'b111);
        drain();

        // Zero bounce and zero hold: every column, multi-key priority, held keys
        cfg_write(REG_BOUNCE, '0);
        cfg_write(REG_HOLD, '0);
        foreach (directed_cols[i])
            send_tick(directed_cols[i]);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == QUIET_PHASE)
                quiet = 1'b1;
            cfg_write(REG_BOUNCE, CNT_W'(bounce_tab[p]));
            cfg_write(REG_HOLD, CNT_W'(hold_tab[p]));
            if (p == 3)
                long_hold = 1'b1;
            span = bounce_tab[p] + hold_tab[p] + 2;
            if (span > 24)
                span = 24;
            run_keys(count_tab[p], span);
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stalls, one long hold-off to back up the input
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_OFF) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({row_drive, press_valid, press_row, press_column});
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
